FILE: design/lav_pkg.sv
// Shared constants, types and helpers for the look-at view matrix unit.
// No dependencies; the two interfaces aside, every other file imports this package.
package lav_pkg;

    localparam int FRAC_BITS = 16;
    // quotient bits of a normalize divide (result never exceeds 2^FRAC_BITS)
    localparam int QB  = FRAC_BITS + 1;
    localparam int QCW = $clog2(QB);
    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    localparam logic [4:0] OP_RC_LAST = 5'd5;
    localparam logic [4:0] OP_T_LAST  = 5'd20;
    localparam logic [4:0] OP_LAST    = 5'd26;
    localparam logic [3:0] ROW_LAST   = 4'd11;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [1:0] {K_VIEW, K_FULL, K_YAXIS} kind_t;

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][32:0] look;
        logic [2:0][31:0] up;
        logic             degen;
    } pose_t;

    typedef enum logic [2:0] {
        NS_IDLE, NS_FIND, NS_SHIFT, NS_SQUARE, NS_ROOT, NS_DIV_INIT, NS_DIV, NS_DONE
    } norm_state_t;

    typedef enum logic [2:0] {
        ES_IDLE, ES_NORM_LOOK, ES_MAC, ES_START_RC, ES_NORM_RC, ES_START_UP,
        ES_NORM_UP, ES_EMIT
    } eng_state_t;

    typedef enum logic [2:0] {V_UP, V_EYE, V_Z, V_X, V_Y, V_U} vec_t;
    typedef enum logic [2:0] {D_NONE, D_RC, D_Y, D_T, D_BZ} dest_t;

    typedef struct packed {
        vec_t       va;
        logic [1:0] ca;
        vec_t       vb;
        logic [1:0] cb;
        logic       first;
        logic       sub;
        dest_t      dest;
        logic [1:0] dc;
    } mac_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic mac_op_t mk(input vec_t va, input int ca, input vec_t vb,
                                   input int cb, input logic first, input logic sub,
                                   input dest_t d, input int dc);
        mac_op_t o;
        o.va    = va;
        o.ca    = 2'(ca);
        o.vb    = vb;
        o.cb    = 2'(cb);
        o.first = first;
        o.sub   = sub;
        o.dest  = d;
        o.dc    = 2'(dc);
        return o;
    endfunction

    // product schedule: rc = up x z, y = z x x, t = -axis.eye, bz = x x u
    function automatic mac_op_t op_decode(input logic [4:0] op);
        mac_op_t o;
        case (op)
            5'd0:  o = mk(V_UP, 1, V_Z, 2, 1'b1, 1'b0, D_NONE, 0);
            5'd1:  o = mk(V_UP, 2, V_Z, 1, 1'b0, 1'b1, D_RC, 0);
            5'd2:  o = mk(V_UP, 2, V_Z, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd3:  o = mk(V_UP, 0, V_Z, 2, 1'b0, 1'b1, D_RC, 1);
            5'd4:  o = mk(V_UP, 0, V_Z, 1, 1'b1, 1'b0, D_NONE, 0);
            5'd5:  o = mk(V_UP, 1, V_Z, 0, 1'b0, 1'b1, D_RC, 2);
            5'd6:  o = mk(V_Z, 1, V_X, 2, 1'b1, 1'b0, D_NONE, 0);
            5'd7:  o = mk(V_Z, 2, V_X, 1, 1'b0, 1'b1, D_Y, 0);
            5'd8:  o = mk(V_Z, 2, V_X, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd9:  o = mk(V_Z, 0, V_X, 2, 1'b0, 1'b1, D_Y, 1);
            5'd10: o = mk(V_Z, 0, V_X, 1, 1'b1, 1'b0, D_NONE, 0);
            5'd11: o = mk(V_Z, 1, V_X, 0, 1'b0, 1'b1, D_Y, 2);
            5'd12: o = mk(V_X, 0, V_EYE, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd13: o = mk(V_X, 1, V_EYE, 1, 1'b0, 1'b0, D_NONE, 0);
            5'd14: o = mk(V_X, 2, V_EYE, 2, 1'b0, 1'b0, D_T, 0);
            5'd15: o = mk(V_Y, 0, V_EYE, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd16: o = mk(V_Y, 1, V_EYE, 1, 1'b0, 1'b0, D_NONE, 0);
            5'd17: o = mk(V_Y, 2, V_EYE, 2, 1'b0, 1'b0, D_T, 1);
            5'd18: o = mk(V_Z, 0, V_EYE, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd19: o = mk(V_Z, 1, V_EYE, 1, 1'b0, 1'b0, D_NONE, 0);
            5'd20: o = mk(V_Z, 2, V_EYE, 2, 1'b0, 1'b0, D_T, 2);
            5'd21: o = mk(V_X, 1, V_U, 2, 1'b1, 1'b0, D_NONE, 0);
            5'd22: o = mk(V_X, 2, V_U, 1, 1'b0, 1'b1, D_BZ, 0);
            5'd23: o = mk(V_X, 2, V_U, 0, 1'b1, 1'b0, D_NONE, 0);
            5'd24: o = mk(V_X, 0, V_U, 2, 1'b0, 1'b1, D_BZ, 1);
            5'd25: o = mk(V_X, 0, V_U, 1, 1'b1, 1'b0, D_NONE, 0);
            5'd26: o = mk(V_X, 1, V_U, 0, 1'b0, 1'b1, D_BZ, 2);
            default: o = mk(V_UP, 0, V_UP, 0, 1'b1, 1'b0, D_NONE, 0);
        endcase
        return o;
    endfunction

    // position of the highest set bit of a nonzero byte
    function automatic logic [2:0] msb8(input logic [7:0] b);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = 3'(i);
        end
        return p;
    endfunction

    // add half an LSB, arithmetic shift by FRAC_BITS, clamp to 32-bit signed
    function automatic logic [31:0] round_sat(input logic signed [65:0] v);
        logic signed [65:0] w;
        logic signed [65:0] s;
        w = v + (66'sd1 <<< (FRAC_BITS - 1));
        s = w >>> FRAC_BITS;
        if (s > SAT_MAX) return 32'h7FFFFFFF;
        if (s < SAT_MIN) return 32'h80000000;
        return s[31:0];
    endfunction

endpackage

FILE: design/lav_pose_if.sv
// Pose channel: valid/ready plus eye, target and up vectors.
// Depends on nothing.
interface lav_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_in_x;
    logic signed [31:0] up_in_y;
    logic signed [31:0] up_in_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_in_x, up_in_y, up_in_z, input ready);
    modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_in_x, up_in_y, up_in_z, output ready);
endinterface

FILE: design/lav_row_if.sv
// Row channel: valid/ready plus one matrix row and its tags.
// Depends on nothing.
interface lav_row_if;
    logic               valid;
    logic               ready;
    logic [1:0]         matrix_kind;
    logic [1:0]         row_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic               degenerate;
    logic               last_row;

    modport source (output valid, matrix_kind, row_index, elem0, elem1, elem2, elem3,
                    degenerate, last_row, input ready);
    modport sink (input valid, matrix_kind, row_index, elem0, elem1, elem2, elem3,
                  degenerate, last_row, output ready);
endinterface

FILE: design/look_at_view_matrix_top.sv
// Top level of the left-handed look-at view matrix unit.
// Uses lav_pkg, lav_pose_if, lav_row_if, lav_front, lav_fifo, lav_engine.
//
//   channel  dir  payload                                        per transaction
//   pose     in   eye/target/up_in x,y,z (Q16.16)                one camera pose
//   rows     out  matrix_kind, row_index, elem0..3, degenerate,  one matrix row,
//                 last_row                                       twelve per pose
//
// A pose's processing time is set by the shared normalize unit (32-step square root,
// one FRAC_BITS+1 step divide per component, three normalizes per pose) and the
// shared multiply, whose product is registered before it is accumulated. Rows
// leave at one per cycle when rows.ready is high. The two-entry queue keeps
// taking poses while the engine works, until it is full; reset needs no clearing
// pass. A stalled row holds in the output register.
module look_at_view_matrix_top (
    input  logic       clk,
    input  logic       rst_n,
    lav_pose_if.sink   pose,
    lav_row_if.source  rows
);
    import lav_pkg::*;

    fifo_status_t status;
    logic         push;
    logic         pop;
    pose_t        item;
    pose_t        head;

    lav_front u_front (
        .pose   (pose),
        .status (status),
        .push   (push),
        .item   (item)
    );

    lav_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (item),
        .pop    (pop),
        .dout   (head),
        .status (status)
    );

    lav_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .have  (!status.empty),
        .pop   (pop),
        .rows  (rows)
    );

endmodule

FILE: design/lav_norm.sv
// Iterative 3-vector normalize: byte-wise leading-one search, rescale,
// sum of squares, bit-serial square root and restoring divide. Uses lav_pkg.
module lav_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0][63:0] vin,
    output logic             done,
    output logic [2:0][31:0] vout
);
    import lav_pkg::*;

    norm_state_t      state_reg, state_next;
    logic [2:0][63:0] mag_reg, mag_next;
    logic [2:0]       neg_reg, neg_next;
    logic [63:0]      max_reg, max_next;
    logic [2:0]       grp_reg, grp_next;
    logic [6:0]       bl_reg, bl_next;
    logic [2:0][29:0] sh_reg, sh_next;
    logic [1:0]       idx_reg, idx_next;
    logic [63:0]      sum_reg, sum_next;
    logic [63:0]      root_reg, root_next;
    logic [4:0]       step_reg, step_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      rem_reg, rem_next;
    logic [QB-1:0]    div_reg, div_next;
    logic [QB-1:0]    quo_reg, quo_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic [2:0][31:0] vout_reg, vout_next;

    assign done = (state_reg == NS_DONE);
    assign vout = vout_reg;

    always_comb begin
        logic [2:0][63:0] mg;
        logic [63:0]      mx;
        logic [7:0]       byte_v;
        logic [59:0]      sq;
        logic [63:0]      bit_v;
        logic [63:0]      trial;
        logic [63:0]      dvd;
        logic [32:0]      r2;
        logic             qbit;
        logic [QB-1:0]    quo_n;
        logic [31:0]      q32;

        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        max_next   = max_reg;
        grp_next   = grp_reg;
        bl_next    = bl_reg;
        sh_next    = sh_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        vout_next  = vout_reg;

        mg     = '0;
        mx     = '0;
        byte_v = max_reg[{grp_reg, 3'b000} +: 8];
        sq     = sh_reg[idx_reg] * sh_reg[idx_reg];
        bit_v  = 64'd1 << {step_reg, 1'b0};
        trial  = root_reg + bit_v;
        dvd    = ({34'd0, sh_reg[idx_reg]} << FRAC_BITS) + {33'd0, len_reg[31:1]};
        r2     = {rem_reg, div_reg[cnt_reg]};
        qbit   = (r2 >= {1'b0, len_reg});
        quo_n  = {quo_reg[QB-2:0], qbit};
        q32    = 32'(quo_n);

        case (state_reg)
            NS_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        mg[i] = vin[i][63] ? (64'd0 - vin[i]) : vin[i];
                        if (mg[i] > mx) mx = mg[i];
                        neg_next[i] = vin[i][63];
                    end
                    mag_next = mg;
                    max_next = mx;
                    grp_next = 3'd7;
                    if (mx == 64'd0) begin
                        vout_next  = '0;
                        state_next = NS_DONE;
                    end else begin
                        state_next = NS_FIND;
                    end
                end
            end
            NS_FIND: begin
                if (byte_v != 8'd0) begin
                    bl_next    = {1'b0, grp_reg, 3'b000} + {4'd0, msb8(byte_v)} + 7'd1;
                    idx_next   = 2'd0;
                    state_next = NS_SHIFT;
                end else begin
                    grp_next = grp_reg - 3'd1;
                end
            end
            NS_SHIFT: begin
                // largest magnitude lands in [2^29, 2^30)
                if (bl_reg > 7'd30) begin
                    sh_next[idx_reg] = 30'(mag_reg[idx_reg] >> (bl_reg - 7'd30));
                end else begin
                    sh_next[idx_reg] = 30'(mag_reg[idx_reg] << (7'd30 - bl_reg));
                end
                if (idx_reg == 2'd2) begin
                    idx_next   = 2'd0;
                    sum_next   = '0;
                    state_next = NS_SQUARE;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            NS_SQUARE: begin
                sum_next = sum_reg + {4'd0, sq};
                if (idx_reg == 2'd2) begin
                    root_next  = '0;
                    step_next  = 5'd31;
                    state_next = NS_ROOT;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            NS_ROOT: begin
                if (sum_reg >= trial) begin
                    sum_next  = sum_reg - trial;
                    root_next = (root_reg >> 1) + bit_v;
                end else begin
                    root_next = root_reg >> 1;
                end
                if (step_reg == 5'd0) begin
                    len_next   = (root_next == 64'd0) ? 32'd1 : root_next[31:0];
                    idx_next   = 2'd0;
                    state_next = NS_DIV_INIT;
                end else begin
                    step_next = step_reg - 5'd1;
                end
            end
            NS_DIV_INIT: begin
                rem_next   = 32'(dvd >> QB);
                div_next   = dvd[QB-1:0];
                quo_next   = '0;
                cnt_next   = QCW'(QB - 1);
                state_next = NS_DIV;
            end
            NS_DIV: begin
                rem_next = qbit ? 32'(r2 - {1'b0, len_reg}) : r2[31:0];
                quo_next = quo_n;
                if (cnt_reg == '0) begin
                    vout_next[idx_reg] = neg_reg[idx_reg] ? (32'd0 - q32) : q32;
                    if (idx_reg == 2'd2) begin
                        state_next = NS_DONE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = NS_DIV_INIT;
                    end
                end else begin
                    cnt_next = cnt_reg - QCW'(1);
                end
            end
            NS_DONE: begin
                state_next = NS_IDLE;
            end
            default: begin
                state_next = NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= NS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        max_reg  <= max_next;
        grp_reg  <= grp_next;
        bl_reg   <= bl_next;
        sh_reg   <= sh_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        root_reg <= root_next;
        step_reg <= step_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        vout_reg <= vout_next;
    end

endmodule

FILE: design/lav_front.sv
// Front end: takes pose transactions, forms target - eye and flags
// degenerate poses, then pushes into the queue. Uses lav_pkg, lav_pose_if.
module lav_front (
    lav_pose_if.sink             pose,
    input  lav_pkg::fifo_status_t status,
    output logic                 push,
    output lav_pkg::pose_t       item
);
    import lav_pkg::*;

    logic [2:0][31:0] eye;
    logic [2:0][31:0] tgt;
    logic [2:0][31:0] up;

    assign eye = {pose.eye_z, pose.eye_y, pose.eye_x};
    assign tgt = {pose.target_z, pose.target_y, pose.target_x};
    assign up  = {pose.up_in_z, pose.up_in_y, pose.up_in_x};

    assign pose.ready = !status.full;
    assign push       = pose.valid && !status.full;

    always_comb begin
        item.eye = eye;
        item.up  = up;
        for (int i = 0; i < 3; i++) begin
            item.look[i] = {tgt[i][31], tgt[i]} - {eye[i][31], eye[i]};
        end
        item.degen = (item.look == '0) || (up == '0);
    end

endmodule

FILE: design/lav_fifo.sv
// Two-entry queue of classified poses between front end and engine.
// Uses lav_pkg.
module lav_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lav_pkg::pose_t        din,
    input  logic                  pop,
    output lav_pkg::pose_t        dout,
    output lav_pkg::fifo_status_t status
);
    import lav_pkg::*;

    pose_t      mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign dout         = mem_reg[rd_reg];
    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) mem_reg[wr_reg] <= din;
    end

endmodule

FILE: design/lav_engine.sv
// Back end: sequences the normalize unit and a shared 32x32 multiplier to
// build the axes and translation, then streams twelve rows through an
// output register. Uses lav_pkg, lav_norm, lav_row_if.
module lav_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  lav_pkg::pose_t head,
    input  logic           have,
    output logic           pop,
    lav_row_if.source      rows
);
    import lav_pkg::*;

    eng_state_t       state_reg, state_next;
    logic [2:0][31:0] eye_reg, eye_next;
    logic [2:0][31:0] up_reg, up_next;
    logic             degen_reg, degen_next;
    logic [2:0][31:0] z_reg, z_next;
    logic [2:0][31:0] x_reg, x_next;
    logic [2:0][31:0] y_reg, y_next;
    logic [2:0][31:0] u_reg, u_next;
    logic [2:0][31:0] bz_reg, bz_next;
    logic [2:0][31:0] t_reg, t_next;
    logic [2:0][63:0] rc_reg, rc_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [4:0]       op_reg, op_next;
    logic             phase_reg, phase_next;
    logic [3:0]       row_reg, row_next;

    logic             ov_reg, ov_next;
    logic [1:0]       kind_reg, kind_next;
    logic [1:0]       ridx_reg, ridx_next;
    logic [3:0][31:0] el_reg, el_next;
    logic             odeg_reg, odeg_next;
    logic             last_reg, last_next;

    logic             norm_start;
    logic [2:0][63:0] norm_vin;
    logic             norm_done;
    logic [2:0][31:0] norm_vout;

    lav_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vin   (norm_vin),
        .done  (norm_done),
        .vout  (norm_vout)
    );

    function automatic logic [31:0] pick(input vec_t v, input logic [1:0] c,
                                         input logic [2:0][31:0] up,
                                         input logic [2:0][31:0] eye,
                                         input logic [2:0][31:0] z,
                                         input logic [2:0][31:0] x,
                                         input logic [2:0][31:0] y,
                                         input logic [2:0][31:0] u);
        case (v)
            V_UP:    return up[c];
            V_EYE:   return eye[c];
            V_Z:     return z[c];
            V_X:     return x[c];
            V_Y:     return y[c];
            V_U:     return u[c];
            default: return 32'd0;
        endcase
    endfunction

    assign rows.valid       = ov_reg;
    assign rows.matrix_kind = kind_reg;
    assign rows.row_index   = ridx_reg;
    assign rows.elem0       = el_reg[0];
    assign rows.elem1       = el_reg[1];
    assign rows.elem2       = el_reg[2];
    assign rows.elem3       = el_reg[3];
    assign rows.degenerate  = odeg_reg;
    assign rows.last_row    = last_reg;

    always_comb begin
        norm_start = 1'b0;
        norm_vin   = '0;
        pop        = 1'b0;
        case (state_reg)
            ES_IDLE: begin
                pop        = have;
                norm_start = have;
                for (int i = 0; i < 3; i++) begin
                    norm_vin[i] = {{31{head.look[i][32]}}, head.look[i]};
                end
            end
            ES_START_RC: begin
                norm_start = 1'b1;
                norm_vin   = rc_reg;
            end
            ES_START_UP: begin
                norm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    norm_vin[i] = {{32{up_reg[i][31]}}, up_reg[i]};
                end
            end
            default: begin
                norm_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        mac_op_t            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [65:0] p;
        logic signed [65:0] acc_n;
        logic               load;
        logic [1:0]         kind;
        logic [3:0][31:0]   el;

        state_next = state_reg;
        eye_next   = eye_reg;
        up_next    = up_reg;
        degen_next = degen_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        u_next     = u_reg;
        bz_next    = bz_reg;
        t_next     = t_reg;
        rc_next    = rc_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        kind_next  = kind_reg;
        ridx_next  = ridx_reg;
        el_next    = el_reg;
        odeg_next  = odeg_reg;
        last_next  = last_reg;

        op    = op_decode(op_reg);
        a     = pick(op.va, op.ca, up_reg, eye_reg, z_reg, x_reg, y_reg, u_reg);
        b     = pick(op.vb, op.cb, up_reg, eye_reg, z_reg, x_reg, y_reg, u_reg);
        p     = op.sub ? -{{2{prod_reg[63]}}, prod_reg} : {{2{prod_reg[63]}}, prod_reg};
        acc_n = op.first ? p : acc_reg + p;
        load  = (state_reg == ES_EMIT) && (!ov_reg || rows.ready);

        case (row_reg[3:2])
            2'd0:    kind = K_VIEW;
            2'd1:    kind = K_FULL;
            default: kind = K_YAXIS;
        endcase
        case (row_reg)
            4'd0:    el = {32'd0, z_reg[0], y_reg[0], x_reg[0]};
            4'd1:    el = {32'd0, z_reg[1], y_reg[1], x_reg[1]};
            4'd2:    el = {32'd0, z_reg[2], y_reg[2], x_reg[2]};
            4'd3:    el = {ONE_Q, t_reg[2], t_reg[1], t_reg[0]};
            4'd4:    el = {32'd0, x_reg};
            4'd5:    el = {32'd0, y_reg};
            4'd6:    el = {32'd0, z_reg};
            4'd8:    el = {32'd0, x_reg};
            4'd9:    el = {32'd0, u_reg};
            4'd10:   el = {32'd0, bz_reg};
            default: el = {ONE_Q, 96'd0};
        endcase

        case (state_reg)
            ES_IDLE: begin
                if (have) begin
                    eye_next   = head.eye;
                    up_next    = head.up;
                    degen_next = head.degen;
                    state_next = ES_NORM_LOOK;
                end
            end
            ES_NORM_LOOK: begin
                if (norm_done) begin
                    z_next     = norm_vout;
                    op_next    = '0;
                    phase_next = 1'b0;
                    state_next = ES_MAC;
                end
            end
            ES_MAC: begin
                if (!phase_reg) begin
                    prod_next  = a * b;
                    phase_next = 1'b1;
                end else begin
                    acc_next   = acc_n;
                    phase_next = 1'b0;
                    op_next    = op_reg + 5'd1;
                    case (op.dest)
                        D_RC:    rc_next[op.dc] = acc_n[63:0];
                        D_Y:     y_next[op.dc]  = round_sat(acc_n);
                        D_T:     t_next[op.dc]  = round_sat(-acc_n);
                        D_BZ:    bz_next[op.dc] = round_sat(acc_n);
                        default: acc_next = acc_n;
                    endcase
                    if (op_reg == OP_RC_LAST) state_next = ES_START_RC;
                    if (op_reg == OP_T_LAST)  state_next = ES_START_UP;
                    if (op_reg == OP_LAST) begin
                        row_next   = '0;
                        state_next = ES_EMIT;
                    end
                end
            end
            ES_START_RC: begin
                state_next = ES_NORM_RC;
            end
            ES_NORM_RC: begin
                if (norm_done) begin
                    x_next     = norm_vout;
                    state_next = ES_MAC;
                end
            end
            ES_START_UP: begin
                state_next = ES_NORM_UP;
            end
            ES_NORM_UP: begin
                if (norm_done) begin
                    u_next     = norm_vout;
                    state_next = ES_MAC;
                end
            end
            ES_EMIT: begin
                if (load) begin
                    kind_next = kind;
                    ridx_next = row_reg[1:0];
                    el_next   = el;
                    odeg_next = degen_reg;
                    last_next = (row_reg == ROW_LAST);
                    row_next  = row_reg + 4'd1;
                    if (row_reg == ROW_LAST) state_next = ES_IDLE;
                end
            end
            default: begin
                state_next = ES_IDLE;
            end
        endcase

        ov_next = load ? 1'b1 : (rows.ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ES_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk) begin
        eye_reg   <= eye_next;
        up_reg    <= up_next;
        degen_reg <= degen_next;
        z_reg     <= z_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        u_reg     <= u_next;
        bz_reg    <= bz_next;
        t_reg     <= t_next;
        rc_reg    <= rc_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        op_reg    <= op_next;
        phase_reg <= phase_next;
        row_reg   <= row_next;
        kind_reg  <= kind_next;
        ridx_reg  <= ridx_next;
        el_reg    <= el_next;
        odeg_reg  <= odeg_next;
        last_reg  <= last_next;
    end

endmodule

FILE: design/lav_checker.sv
// Port-level checks on the row stream of the look-at unit, bound to the top.
// Uses lav_pkg.
module lav_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [1:0]  matrix_kind,
    input logic [1:0]  row_index,
    input logic [31:0] elem0,
    input logic [31:0] elem1,
    input logic [31:0] elem2,
    input logic [31:0] elem3,
    input logic        last_row
);
    import lav_pkg::*;

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_row |-> row_index == 2'd3 && matrix_kind == K_YAXIS)
        else $error("last_row off the final row");

    a_elem3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && row_index != 2'd3 |-> elem3 == 32'd0)
        else $error("nonzero elem3 on an axis row");

    a_billboard_tail: assert property (@(posedge clk) disable iff (!rst_n)
        valid && row_index == 2'd3 && matrix_kind != K_VIEW |->
            elem0 == 32'd0 && elem1 == 32'd0 && elem2 == 32'd0 && elem3 == ONE_Q)
        else $error("billboard last row is not identity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(row_index) && $stable(elem0))
        else $error("stalled row changed");

endmodule

bind look_at_view_matrix_top lav_checker u_lav_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (rows.valid),
    .ready       (rows.ready),
    .matrix_kind (rows.matrix_kind),
    .row_index   (rows.row_index),
    .elem0       (rows.elem0),
    .elem1       (rows.elem1),
    .elem2       (rows.elem2),
    .elem3       (rows.elem3),
    .last_row    (rows.last_row)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for look_at_view_matrix_top: a pose predictor models the fixed-point
// math and checks every matrix row. Depends on lav_pkg, lav_pose_if, lav_row_if and the top.
module testbench;
    import lav_pkg::*;

    logic clk;
    logic rst_n;
    lav_pose_if pose ();
    lav_row_if  rows ();

    look_at_view_matrix_top u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pose (pose),
        .rows (rows)
    );

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  row;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] e2;
        logic [31:0] e3;
        logic        degen;
        logic        last;
    } row_t;

    typedef logic signed [63:0] s64;

    row_t   expected_rows[$];
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 0;
    longint cycle_count = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 64'd3000000)
        begin
            $display("[look_at_view_matrix_top] ERROR");
            $finish;
        end
    end

    function automatic s64 sat32(input s64 v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic s64 round_shift(input s64 v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // scale so the largest magnitude lands in [2^29, 2^30), then divide by length
    function automatic void to_unit(input s64 v[3], output s64 o[3]);
        logic [63:0] mag[3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        int bl;
        int sh;
        m = 0;
        sum = 0;
        bl = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            o = '{0, 0, 0};
            return;
        end
        while (bl < 64 && (m >> bl) != 0)
            bl++;
        sh = bl - 30;
        for (int i = 0; i < 3; i++)
        begin
            if (sh > 0)
                mag[i] >>= sh;
            else if (sh < 0)
                mag[i] <<= -sh;
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FRAC_BITS) + len / 2) / len;
            if (q > 64'd2147483647)
                q = 64'd2147483647;
            o[i] = v[i] < 0 ? -s64'(q) : s64'(q);
        end
    endfunction

    function automatic void unit_cross(input s64 a[3], input s64 b[3], output s64 o[3]);
        o[0] = sat32(round_shift(a[1] * b[2] - a[2] * b[1]));
        o[1] = sat32(round_shift(a[2] * b[0] - a[0] * b[2]));
        o[2] = sat32(round_shift(a[0] * b[1] - a[1] * b[0]));
    endfunction

    function automatic row_t mk_row(input kind_t k, input int r, input s64 a, input s64 b,
                                    input s64 c, input s64 d, input logic dg);
        row_t x;
        x.kind  = k;
        x.row   = 2'(r);
        x.e0    = a[31:0];
        x.e1    = b[31:0];
        x.e2    = c[31:0];
        x.e3    = d[31:0];
        x.degen = dg;
        x.last  = (k == K_YAXIS && r == 3);
        return x;
    endfunction

    task automatic predict_matrices(input logic [31:0] in[9]);
        s64 eye[3], up[3], look[3], z[3], rc[3], xa[3], ya[3], u[3], bz[3], t[3];
        s64 one;
        s64 d;
        logic dg;
        one = s64'(1) <<< FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = s64'($signed(in[i]));
            look[i] = s64'($signed(in[3 + i])) - eye[i];
            up[i]   = s64'($signed(in[6 + i]));
        end
        dg = ((look[0] | look[1] | look[2]) == 0) || ((up[0] | up[1] | up[2]) == 0);
        to_unit(look, z);
        rc[0] = up[1] * z[2] - up[2] * z[1];
        rc[1] = up[2] * z[0] - up[0] * z[2];
        rc[2] = up[0] * z[1] - up[1] * z[0];
        to_unit(rc, xa);
        unit_cross(z, xa, ya);
        for (int i = 0; i < 3; i++)
        begin
            if (i == 0)
                d = xa[0] * eye[0] + xa[1] * eye[1] + xa[2] * eye[2];
            else if (i == 1)
                d = ya[0] * eye[0] + ya[1] * eye[1] + ya[2] * eye[2];
            else
                d = z[0] * eye[0] + z[1] * eye[1] + z[2] * eye[2];
            t[i] = sat32(round_shift(-d));
        end
        to_unit(up, u);
        unit_cross(xa, u, bz);
        for (int i = 0; i < 3; i++)
            expected_rows.push_back(mk_row(K_VIEW, i, xa[i], ya[i], z[i], 0, dg));
        expected_rows.push_back(mk_row(K_VIEW, 3, t[0], t[1], t[2], one, dg));
        expected_rows.push_back(mk_row(K_FULL, 0, xa[0], xa[1], xa[2], 0, dg));
        expected_rows.push_back(mk_row(K_FULL, 1, ya[0], ya[1], ya[2], 0, dg));
        expected_rows.push_back(mk_row(K_FULL, 2, z[0], z[1], z[2], 0, dg));
        expected_rows.push_back(mk_row(K_FULL, 3, 0, 0, 0, one, dg));
        expected_rows.push_back(mk_row(K_YAXIS, 0, xa[0], xa[1], xa[2], 0, dg));
        expected_rows.push_back(mk_row(K_YAXIS, 1, u[0], u[1], u[2], 0, dg));
        expected_rows.push_back(mk_row(K_YAXIS, 2, bz[0], bz[1], bz[2], 0, dg));
        expected_rows.push_back(mk_row(K_YAXIS, 3, 0, 0, 0, one, dg));
    endtask

    // offer one pose; prediction is queued at acceptance, valid stays up for the next one
    task automatic send_pose(input logic [31:0] in[9]);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            pose.valid <= 1'b0;
            @(posedge clk);
        end
        pose.valid    <= 1'b1;
        pose.eye_x    <= in[0];
        pose.eye_y    <= in[1];
        pose.eye_z    <= in[2];
        pose.target_x <= in[3];
        pose.target_y <= in[4];
        pose.target_z <= in[5];
        pose.up_in_x  <= in[6];
        pose.up_in_y  <= in[7];
        pose.up_in_z  <= in[8];
        @(posedge clk);
        while (!pose.ready)
            @(posedge clk);
        predict_matrices(in);
    endtask

    // receiver ready, with random stalls and a forced hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows.ready <= 1'b0;
        else
            rows.ready <= !hold_off &&
                          (recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        row_t got;
        row_t want;
        if (rst_n && rows.valid && rows.ready)
        begin
            got = '{rows.matrix_kind, rows.row_index, rows.elem0, rows.elem1, rows.elem2,
                    rows.elem3, rows.degenerate, rows.last_row};
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row transaction kind=%0d row=%0d", got.kind, got.row);
                error_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("matrix_kind exp %0d got %0d", want.kind, got.kind);
                    error_count++;
                end
                if (got.row !== want.row)
                begin
                    $error("row_index exp %0d got %0d", want.row, got.row);
                    error_count++;
                end
                if (got.e0 !== want.e0)
                begin
                    $error("elem0 exp %h got %h", want.e0, got.e0);
                    error_count++;
                end
                if (got.e1 !== want.e1)
                begin
                    $error("elem1 exp %h got %h", want.e1, got.e1);
                    error_count++;
                end
                if (got.e2 !== want.e2)
                begin
                    $error("elem2 exp %h got %h", want.e2, got.e2);
                    error_count++;
                end
                if (got.e3 !== want.e3)
                begin
                    $error("elem3 exp %h got %h", want.e3, got.e3);
                    error_count++;
                end
                if (got.degen !== want.degen)
                begin
                    $error("degenerate exp %0d got %0d", want.degen, got.degen);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_row exp %0d got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(20)) - 10) <<< FRAC_BITS;
            2:       return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            3:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 4;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [31:0] in[9];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                in[i] = rand_word();
            case ($urandom_range(9))
                0: in[3:5] = in[0:2];                 // target on eye
                1: in[6:8] = '{0, 0, 0};              // no up vector
                2: in[6:8] = '{in[3] - in[0], in[4] - in[1], in[5] - in[2]}; // up along look
                default: ;
            endcase
            send_pose(in);
        end
    endtask

    task automatic wait_drained();
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        send_pose('{0, 0, 0, 0, 0, ONE_Q, 0, ONE_Q, 0});
        send_pose('{ONE_Q, 2 * ONE_Q, -3 * ONE_Q, 0, 0, 0, 0, ONE_Q, 0});
        send_pose('{ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, ONE_Q, 0});   // target on eye
        send_pose('{0, 0, 0, ONE_Q, 0, 0, 0, 0, 0});                          // zero up
        send_pose('{0, 0, 0, 0, 0, ONE_Q, 0, 0, 5 * ONE_Q});                  // up along look
        send_pose('{mn, mn, mn, mx, mx, mx, mx, mn, mx});
        send_pose('{mx, mx, mx, mn, mn, mn, mn, mx, mn});
        send_pose('{mx, mn, mx, mn, mx, 0, 1, 0, 0});                         // big translation
        send_pose('{mx, mx, mx, mx - 1, mx, mx, 0, 1, 0});
        send_pose('{0, 0, 0, 1, 1, 1, mx, mx, mx});
        send_pose('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 32'h55555555,
                    32'hAAAAAAAA, 32'h0F0F0F0F});
        send_pose('{32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA,
                    32'h0F0F0F0F, mn, mn, mn});
        pose.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(70);
        send_idle_pct = 73; recv_stall_pct = 0;  send_random(70);
        send_idle_pct = 0;  recv_stall_pct = 73; send_random(70);
        send_idle_pct = 35; recv_stall_pct = 35; send_random(70);
        pose.valid <= 1'b0;
        wait_drained();
    endtask

    // rows held back long enough that the pose queue fills and stalls input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        fork
            begin
                int held;
                held = 0;
                while (held < 3000)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_off = 0;
            end
            begin
                send_random(8);
                pose.valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n = 0;
        pose.valid = 0;
        pose.eye_x = 0;
        pose.eye_y = 0;
        pose.eye_z = 0;
        pose.target_x = 0;
        pose.target_y = 0;
        pose.target_z = 0;
        pose.up_in_x = 0;
        pose.up_in_y = 0;
        pose.up_in_z = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        if (error_count == 0)
            $display("[look_at_view_matrix_top] OK");
        else
            $display("[look_at_view_matrix_top] ERROR");
        $finish;
    end
endmodule
